// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/ahre_pkg.sv -----
`default_nettype none
package ahre_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int THRESH_W      = 8;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_HOLD    = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_COEF  = 2'd0,
        CFG_RELEASE_COEF = 2'd1,
        CFG_HOLD_STEP    = 2'd2,
        CFG_SETTLE_THR   = 2'd3
    } t_cfg_idx;

    localparam logic [63:0] RST_ATTACK_COEF  = 64'd16773721;
    localparam logic [63:0] RST_RELEASE_COEF = 64'd16773721;
    localparam logic [63:0] RST_HOLD_STEP    = 64'd3495;
    localparam logic [THRESH_W-1:0] RST_SETTLE_THR = 8'd1;

endpackage
`default_nettype wire

// ----- rtl/core/attack_hold_release_envelope_top.sv -----
// attack-hold-release envelope, one result per request
// the result is registered at the clock edge that accepts the request
// throughput: one request per cycle while the consumer takes results; a full, unread output stalls
// a full output register still accepts a request when the consumer takes the result
// reset (synchronous, active low): idle stage, last level and hold timer zero, registers at defaults
`default_nettype none
module attack_hold_release_envelope_top #(
    parameter int FRAC_BITS = ahre_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_trigger,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [FRAC_BITS:0]             o_level,
    output logic      [1:0]                     o_stage,
    input  wire logic                           i_cfg_we,
    input  wire logic [ahre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAC_BITS:0]             i_cfg_data
);
    import ahre_pkg::*;

    localparam logic [FRAC_BITS:0] UNITY   = {1'b1, {FRAC_BITS{1'b0}}};
    // largest level that can end a release
    localparam logic [FRAC_BITS:0] THR_MAX = (FRAC_BITS+1)'({THRESH_W{1'b1}});

    logic [FRAC_BITS-1:0] attack_coef;
    logic [FRAC_BITS-1:0] release_coef;
    logic [FRAC_BITS:0]   hold_step;
    logic [THRESH_W-1:0]  settle_thr;

    t_stage               r_stage;
    logic [FRAC_BITS:0]   r_last_level;
    logic [FRAC_BITS+1:0] r_hold_timer;
    logic                 r_valid;
    logic [FRAC_BITS:0]   r_level;
    t_stage               r_out_stage;

    t_stage               n_stage;
    logic [FRAC_BITS:0]   n_level;
    logic [FRAC_BITS:0]   n_last_level;
    logic [FRAC_BITS+1:0] n_hold_timer;

    logic accept;

    ahre_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_attack_coef  (attack_coef),
        .o_release_coef (release_coef),
        .o_hold_step    (hold_step),
        .o_settle_thr   (settle_thr)
    );

    ahre_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .i_trigger         (i_trigger),
        .i_stage           (r_stage),
        .i_last_level      (r_last_level),
        .i_hold_timer      (r_hold_timer),
        .i_attack_coef     (attack_coef),
        .i_release_coef    (release_coef),
        .i_hold_step       (hold_step),
        .i_settle_thr      (settle_thr),
        .o_stage_next      (n_stage),
        .o_level           (n_level),
        .o_last_level_next (n_last_level),
        .o_hold_timer_next (n_hold_timer)
    );

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ST_IDLE;
            r_last_level <= '0;
            r_hold_timer <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_stage      <= n_stage;
                r_last_level <= n_last_level;
                r_hold_timer <= n_hold_timer;
                r_valid      <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_level     <= n_level;
            r_out_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;
    assign o_stage = r_out_stage;

`include "assert_macros.svh"

    `AST_SAME(a_level_range, i_clk, i_rst_n, o_valid, o_level <= UNITY)
    `AST_SAME(a_idle_small, i_clk, i_rst_n, o_valid && (r_out_stage == ST_IDLE), o_level <= THR_MAX)
    `AST_NEXT(a_trig_attack, i_clk, i_rst_n, accept && i_trigger,
        o_valid && ((r_out_stage == ST_ATTACK) || (r_out_stage == ST_HOLD)))
    `AST_NEXT(a_release_decay, i_clk, i_rst_n, accept && !i_trigger && (r_stage == ST_RELEASE),
        r_last_level <= $past(r_last_level))

endmodule
`default_nettype wire

// ----- rtl/core/ahre_cfg_regs.sv -----
`default_nettype none
module ahre_cfg_regs #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ahre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [FRAC_BITS:0]                i_cfg_data,
    output logic      [FRAC_BITS-1:0]              o_attack_coef,
    output logic      [FRAC_BITS-1:0]              o_release_coef,
    output logic      [FRAC_BITS:0]                o_hold_step,
    output logic      [ahre_pkg::THRESH_W-1:0]     o_settle_thr
);
    import ahre_pkg::*;

    logic [FRAC_BITS-1:0] r_attack_coef;
    logic [FRAC_BITS-1:0] r_release_coef;
    logic [FRAC_BITS:0]   r_hold_step;
    logic [THRESH_W-1:0]  r_settle_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coef  <= RST_ATTACK_COEF[FRAC_BITS-1:0];
            r_release_coef <= RST_RELEASE_COEF[FRAC_BITS-1:0];
            r_hold_step    <= RST_HOLD_STEP[FRAC_BITS:0];
            r_settle_thr   <= RST_SETTLE_THR;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ATTACK_COEF:  r_attack_coef  <= i_cfg_data[FRAC_BITS-1:0];
                CFG_RELEASE_COEF: r_release_coef <= i_cfg_data[FRAC_BITS-1:0];
                CFG_HOLD_STEP:    r_hold_step    <= i_cfg_data;
                CFG_SETTLE_THR:   r_settle_thr   <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_attack_coef  = r_attack_coef;
    assign o_release_coef = r_release_coef;
    assign o_hold_step    = r_hold_step;
    assign o_settle_thr   = r_settle_thr;

endmodule
`default_nettype wire

// ----- rtl/core/ahre_step.sv -----
`default_nettype none
module ahre_step #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                          i_trigger,
    input  wire ahre_pkg::t_stage              i_stage,
    input  wire logic [FRAC_BITS:0]            i_last_level,
    input  wire logic [FRAC_BITS+1:0]          i_hold_timer,
    input  wire logic [FRAC_BITS-1:0]          i_attack_coef,
    input  wire logic [FRAC_BITS-1:0]          i_release_coef,
    input  wire logic [FRAC_BITS:0]            i_hold_step,
    input  wire logic [ahre_pkg::THRESH_W-1:0] i_settle_thr,
    output ahre_pkg::t_stage                   o_stage_next,
    output logic      [FRAC_BITS:0]            o_level,
    output logic      [FRAC_BITS:0]            o_last_level_next,
    output logic      [FRAC_BITS+1:0]          o_hold_timer_next
);
    import ahre_pkg::*;

    localparam int LW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 2;
    localparam int PW = 2 * FRAC_BITS + 1;
    localparam logic [LW-1:0] UNITY = {1'b1, {FRAC_BITS{1'b0}}};

    t_stage               stage_eff;
    logic [FRAC_BITS-1:0] coef;
    logic [PW-1:0]        prod;
    logic [LW-1:0]        scaled;
    logic [TW-1:0]        attack_sum;
    logic [LW-1:0]        attack_lvl;
    logic                 attack_settled;
    logic [TW:0]          timer_sum;
    logic [TW-1:0]        timer_sat;

    // a trigger forces attack before this tick is evaluated
    assign stage_eff = i_trigger ? ST_ATTACK : i_stage;

    // one shared multiplier: attack and release never run in the same tick
    assign coef   = (stage_eff == ST_ATTACK) ? i_attack_coef : i_release_coef;
    assign prod   = PW'(coef) * PW'(i_last_level);
    assign scaled = prod[PW-1:FRAC_BITS];

    assign attack_sum = TW'(scaled) + TW'(UNITY) - TW'(coef);
    assign attack_lvl = (attack_sum > TW'(UNITY)) ? UNITY : attack_sum[LW-1:0];
    assign attack_settled = TW'(attack_lvl) <= (TW'(i_last_level) + TW'(i_settle_thr));

    // saturate at all ones of the timer width
    assign timer_sum = (TW+1)'(i_hold_timer) + (TW+1)'(i_hold_step);
    assign timer_sat = timer_sum[TW] ? {TW{1'b1}} : timer_sum[TW-1:0];

    always_comb begin
        o_stage_next      = stage_eff;
        o_level           = '0;
        o_last_level_next = i_last_level;
        o_hold_timer_next = i_hold_timer;
        case (stage_eff)
            ST_ATTACK: begin
                o_level           = attack_lvl;
                o_last_level_next = attack_lvl;
                if (attack_settled) begin
                    o_stage_next      = ST_HOLD;
                    o_hold_timer_next = '0;
                end
            end
            ST_HOLD: begin
                o_level           = i_last_level;
                o_hold_timer_next = timer_sat;
                if (timer_sat >= TW'(UNITY)) begin
                    o_stage_next = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                o_level           = scaled;
                o_last_level_next = scaled;
                if (scaled <= LW'(i_settle_thr)) begin
                    o_stage_next = ST_IDLE;
                end
            end
            default: begin
                o_level = '0;
            end
        endcase
    end

endmodule
`default_nettype wire
